// ===== rtl/i2cm_pkg.sv =====
// shared types, command codes and constants of the i2c master bit sequencer
package i2cm_pkg;

    localparam int DELAY_WIDTH_DEF = 8;
    localparam int CFG_WIDTH       = 8;
    localparam logic [CFG_WIDTH-1:0] HALF_RESET = 8'd10;

    localparam int PHASE_WIDTH = 5;
    localparam logic [PHASE_WIDTH-1:0] WRITE_PHASES     = 5'd24;
    localparam logic [PHASE_WIDTH-1:0] READ_PHASES      = 5'd16;
    localparam logic [PHASE_WIDTH-1:0] SHORT_PHASES     = 5'd3;
    localparam logic [PHASE_WIDTH-1:0] WRITE_LAST_PHASE = 5'd23;

    typedef enum logic [2:0] {
        FN_START   = 3'd0,
        FN_STOP    = 3'd1,
        FN_WRITE   = 3'd2,
        FN_READ    = 3'd3,
        FN_WAITACK = 3'd4,
        FN_ACK     = 3'd5,
        FN_NACK    = 3'd6
    } t_func;

    typedef struct packed {
        logic       cmd_valid;
        logic [2:0] func;
        logic [7:0] tx_byte;
        logic       sda_in;
    } t_in;

    typedef struct packed {
        logic       scl_out;
        logic       sda_out;
        logic       busy_res;
        logic       done_res;
        logic [7:0] rx_byte;
        logic       ack_received;
    } t_out;

endpackage

// ===== rtl/i2cm_core.sv =====
// sequencer state and one-tick step logic of the i2c master
module i2cm_core
    import i2cm_pkg::*;
#(
    parameter int DELAY_WIDTH = DELAY_WIDTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_step,
    input  t_in                  i_item,
    input  logic [CFG_WIDTH-1:0] i_half,
    output t_out                 o_res
);

    localparam int HW = (DELAY_WIDTH > CFG_WIDTH) ? DELAY_WIDTH : CFG_WIDTH;
    localparam logic [HW-1:0] MAXV = HW'((1 << DELAY_WIDTH) - 1);

    t_func                  r_cmd,   n_cmd;
    logic [PHASE_WIDTH-1:0] r_phase, n_phase;
    logic [1:0]             r_sub,   n_sub;
    logic [DELAY_WIDTH-1:0] r_tick,  n_tick;
    logic [7:0]             r_shift, n_shift;
    logic                   r_scl,   n_scl;
    logic                   r_sda,   n_sda;
    logic                   r_ack,   n_ack;
    logic                   r_run,   n_run;
    logic [7:0]             r_rx,    n_rx;

    logic [HW-1:0]          len_ext;
    logic [DELAY_WIDTH-1:0] phase_len;
    logic [DELAY_WIDTH-1:0] tick_dec;
    logic [PHASE_WIDTH-1:0] next_phase;
    logic [PHASE_WIDTH-1:0] phase_cnt;
    logic [1:0]             next_sub;
    logic                   enter;
    logic                   done;
    t_func                  ecmd;
    logic [PHASE_WIDTH-1:0] ephase;
    logic [1:0]             esub;

    // hold length: zero reads as one, saturate to the counter range
    always_comb begin
        len_ext = HW'(i_half);
        if (len_ext == '0) begin
            len_ext = HW'(1);
        end
        if (len_ext > MAXV) begin
            len_ext = MAXV;
        end
        phase_len = len_ext[DELAY_WIDTH-1:0];
    end

    always_comb begin
        case (r_cmd)
            FN_WRITE: phase_cnt = WRITE_PHASES;
            FN_READ:  phase_cnt = READ_PHASES;
            default:  phase_cnt = SHORT_PHASES;
        endcase
    end

    always_comb begin
        n_cmd   = r_cmd;
        n_phase = r_phase;
        n_sub   = r_sub;
        n_tick  = r_tick;
        n_shift = r_shift;
        n_scl   = r_scl;
        n_sda   = r_sda;
        n_ack   = r_ack;
        n_run   = r_run;
        n_rx    = r_rx;
        done    = 1'b0;
        enter   = 1'b0;
        ecmd    = r_cmd;
        ephase  = '0;
        esub    = '0;

        tick_dec   = (r_tick != '0) ? (r_tick - DELAY_WIDTH'(1)) : r_tick;
        next_phase = r_phase + PHASE_WIDTH'(1);
        next_sub   = (r_sub == 2'd2) ? 2'd0 : (r_sub + 2'd1);

        if (r_run) begin
            n_tick = tick_dec;
            if (tick_dec == '0) begin
                n_phase = next_phase;
                if (next_phase >= phase_cnt) begin
                    // final pin action and read result
                    if (r_cmd == FN_ACK) begin
                        n_sda = 1'b1;
                    end
                    if (r_cmd == FN_READ) begin
                        n_rx = r_shift;
                    end
                    n_run = 1'b0;
                    done  = 1'b1;
                end else begin
                    enter  = 1'b1;
                    ephase = next_phase;
                    esub   = next_sub;
                end
            end
        end else if (i_item.cmd_valid && (i_item.func <= FN_NACK)) begin
            n_cmd   = t_func'(i_item.func);
            ecmd    = t_func'(i_item.func);
            n_phase = '0;
            n_run   = 1'b1;
            enter   = 1'b1;
            if (i_item.func == FN_WRITE) begin
                n_shift = i_item.tx_byte;
            end
            if (i_item.func == FN_READ) begin
                n_shift = '0;
                n_sda   = 1'b1;
            end
        end

        if (enter) begin
            n_sub  = esub;
            n_tick = phase_len;
            unique case (ecmd)
                FN_START: begin
                    if (ephase == 5'd0) begin
                        n_sda = 1'b1;
                        n_scl = 1'b1;
                    end else if (ephase == 5'd1) begin
                        n_sda = 1'b0;
                    end else begin
                        n_scl = 1'b0;
                    end
                end
                FN_STOP: begin
                    if (ephase == 5'd0) begin
                        n_scl = 1'b0;
                        n_sda = 1'b0;
                    end else if (ephase == 5'd1) begin
                        n_scl = 1'b1;
                    end else begin
                        n_sda = 1'b1;
                    end
                end
                FN_WRITE: begin
                    if (esub == 2'd0) begin
                        n_sda = n_shift[7];
                    end else if (esub == 2'd1) begin
                        n_scl = 1'b1;
                    end else begin
                        n_scl = 1'b0;
                        if (ephase == WRITE_LAST_PHASE) begin
                            n_sda = 1'b1;
                        end
                        n_shift = {n_shift[6:0], 1'b0};
                    end
                end
                FN_READ: begin
                    if (!ephase[0]) begin
                        n_shift = {n_shift[6:0], 1'b0};
                        n_scl   = 1'b1;
                    end else begin
                        n_shift = {n_shift[7:1], n_shift[0] | i_item.sda_in};
                        n_scl   = 1'b0;
                    end
                end
                FN_WAITACK: begin
                    if (ephase == 5'd0) begin
                        n_sda = 1'b1;
                    end else if (ephase == 5'd1) begin
                        n_scl = 1'b1;
                    end else begin
                        n_ack = i_item.sda_in;
                        n_scl = 1'b0;
                    end
                end
                FN_ACK: begin
                    if (ephase == 5'd0) begin
                        n_sda = 1'b0;
                    end else if (ephase == 5'd1) begin
                        n_scl = 1'b1;
                    end else begin
                        n_scl = 1'b0;
                    end
                end
                default: begin
                    if (ephase == 5'd0) begin
                        n_sda = 1'b1;
                    end else if (ephase == 5'd1) begin
                        n_scl = 1'b1;
                    end else begin
                        n_scl = 1'b0;
                    end
                end
            endcase
        end
    end

    always_comb begin
        o_res.scl_out      = n_scl;
        o_res.sda_out      = n_sda;
        o_res.busy_res     = n_run;
        o_res.done_res     = done;
        o_res.rx_byte      = n_rx;
        o_res.ack_received = n_ack;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmd   <= FN_START;
            r_phase <= '0;
            r_sub   <= '0;
            r_tick  <= '0;
            r_shift <= '0;
            r_scl   <= 1'b1;
            r_sda   <= 1'b1;
            r_ack   <= 1'b0;
            r_run   <= 1'b0;
            r_rx    <= '0;
        end else if (i_step) begin
            r_cmd   <= n_cmd;
            r_phase <= n_phase;
            r_sub   <= n_sub;
            r_tick  <= n_tick;
            r_shift <= n_shift;
            r_scl   <= n_scl;
            r_sda   <= n_sda;
            r_ack   <= n_ack;
            r_run   <= n_run;
            r_rx    <= n_rx;
        end
    end

endmodule

// ===== rtl/i2c_master_bit_sequencer.sv =====
// top level of the i2c master bit sequencer: input register, step core, result register
// an accepted tick transaction waits in the input register until the result register can take it
// throughput: one tick transaction per cycle unless the receiver stalls the result register
// once both registers hold an item, a receiver stall blocks the input in that same cycle
// reset: synchronous active-low i_rst_n, half-phase length back to 10, pins released high
module i2c_master_bit_sequencer
    import i2cm_pkg::*;
#(
    parameter int DELAY_WIDTH = DELAY_WIDTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // tick transactions in
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_in                  i_in,
    // results out
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_out                 o_out,
    // half-phase length register write
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_WIDTH-1:0] i_cfg_data
);

    logic                 r_in_valid;
    t_in                  r_in;
    logic                 r_out_valid;
    t_out                 r_out;
    logic [CFG_WIDTH-1:0] r_half;
    t_out                 core_res;
    logic                 advance;
    logic                 in_accept;

    // the registered item moves into the result register when that slot frees up
    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;
    assign in_accept  = i_in_valid && o_in_ready;

    // register writes must only be made while idle; the block does not enforce this and takes them at once
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half <= HALF_RESET;
        end else if (i_cfg_valid) begin
            r_half <= i_cfg_data;
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in <= i_in;
        end
    end

    // pin sequencer state advances by exactly one tick per item
    i2cm_core #(
        .DELAY_WIDTH (DELAY_WIDTH)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (advance),
        .i_item  (r_in),
        .i_half  (r_half),
        .o_res   (core_res)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= core_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

// ===== rtl/i2cm_checker.sv =====
// port-level checker of the i2c master bit sequencer and its bind
module i2cm_checker
    import i2cm_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic o_in_ready,
    input logic o_out_valid,
    input logic i_out_ready,
    input t_out o_out
);

    logic r_prev_busy;

    // busy flag of the last delivered result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_busy <= 1'b0;
        end else if (o_out_valid && i_out_ready) begin
            r_prev_busy <= o_out.busy_res;
        end
    end

    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.done_res |-> !o_out.busy_res)
        else $error("done result still shows busy");

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && o_out.done_res |-> r_prev_busy)
        else $error("done result without a running command before it");

    a_ready_when_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid || i_out_ready |-> o_in_ready)
        else $error("input stalled although the result side moves");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out))
        else $error("stalled result changed or dropped");

endmodule

bind i2c_master_bit_sequencer i2cm_checker u_i2cm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out       (o_out)
);

// ===== tb/tb_i2c_master_bit_sequencer.sv =====
// testbench for the i2c master bit sequencer: per-tick pin prediction with a scoreboard class
`timescale 1ns / 100ps

module tb_i2c_master_bit_sequencer;
    import i2cm_pkg::*;

    // func value that names no command; the block must stay idle on it
    localparam logic [2:0] FN_UNUSED = 3'd7;
    // cycles with no transaction on any channel before the run is called hung
    localparam int QUIET_LIMIT = 4000;
    // result register plus input register, with margin
    localparam int TAIL_CYCLES = 8;

    // tracks the sequencer state tick by tick and holds the pin levels still to arrive
    class sequencer_pin_checker;
        logic [7:0] half_ticks;
        logic [2:0] active_cmd;
        logic [4:0] phase;
        int         hold_left;
        logic [7:0] shift_reg;
        logic       scl_lvl;
        logic       sda_lvl;
        logic       ack_lvl;
        logic       running;
        logic [7:0] rx_last;
        t_out       expected_pins[$];
        int         pin_errors;

        function new();
            half_ticks = HALF_RESET;
            active_cmd = FN_START;
            phase      = '0;
            hold_left  = 0;
            shift_reg  = '0;
            scl_lvl    = 1'b1;
            sda_lvl    = 1'b1;
            ack_lvl    = 1'b0;
            running    = 1'b0;
            rx_last    = '0;
            pin_errors = 0;
        endfunction

        function void set_half(logic [7:0] v);
            half_ticks = v;
        endfunction

        function int pending();
            return expected_pins.size();
        endfunction

        function bit busy();
            return running;
        endfunction

        function int hold_len();
            int h;
            int maxv;
            maxv = (1 << DELAY_WIDTH_DEF) - 1;
            h = half_ticks;
            if (h == 0) h = 1;
            if (h > maxv) h = maxv;
            return h;
        endfunction

        function logic [4:0] phases_of(logic [2:0] c);
            case (t_func'(c))
                FN_WRITE: return WRITE_PHASES;
                FN_READ:  return READ_PHASES;
                default:  return SHORT_PHASES;
            endcase
        endfunction

        function void enter(logic [2:0] c, logic [4:0] p, logic sda_in);
            case (t_func'(c))
                FN_START: begin
                    if (p == 0) begin
                        sda_lvl = 1'b1;
                        scl_lvl = 1'b1;
                    end else if (p == 1) sda_lvl = 1'b0;
                    else scl_lvl = 1'b0;
                end
                FN_STOP: begin
                    if (p == 0) begin
                        scl_lvl = 1'b0;
                        sda_lvl = 1'b0;
                    end else if (p == 1) scl_lvl = 1'b1;
                    else sda_lvl = 1'b1;
                end
                FN_WRITE: begin
                    case (p % 3)
                        0: sda_lvl = shift_reg[7];
                        1: scl_lvl = 1'b1;
                        default: begin
                            scl_lvl = 1'b0;
                            if (p == WRITE_LAST_PHASE) sda_lvl = 1'b1;
                            shift_reg = {shift_reg[6:0], 1'b0};
                        end
                    endcase
                end
                FN_READ: begin
                    if (!p[0]) begin
                        shift_reg = {shift_reg[6:0], 1'b0};
                        scl_lvl   = 1'b1;
                    end else begin
                        shift_reg[0] = sda_in;
                        scl_lvl      = 1'b0;
                    end
                end
                FN_WAITACK: begin
                    if (p == 0) sda_lvl = 1'b1;
                    else if (p == 1) scl_lvl = 1'b1;
                    else begin
                        ack_lvl = sda_in;
                        scl_lvl = 1'b0;
                    end
                end
                FN_ACK: begin
                    if (p == 0) sda_lvl = 1'b0;
                    else if (p == 1) scl_lvl = 1'b1;
                    else scl_lvl = 1'b0;
                end
                default: begin
                    if (p == 0) sda_lvl = 1'b1;
                    else if (p == 1) scl_lvl = 1'b1;
                    else scl_lvl = 1'b0;
                end
            endcase
        endfunction

        // advance one tick and queue the pin levels it leaves behind
        function void note_tick(t_in it);
            t_out pins;
            logic fin;
            fin = 1'b0;
            if (running) begin
                if (hold_left > 0) hold_left--;
                if (hold_left == 0) begin
                    phase = phase + 5'd1;
                    if (phase >= phases_of(active_cmd)) begin
                        if (active_cmd == FN_ACK) sda_lvl = 1'b1;
                        if (active_cmd == FN_READ) rx_last = shift_reg;
                        running = 1'b0;
                        fin     = 1'b1;
                    end else begin
                        enter(active_cmd, phase, it.sda_in);
                        hold_left = hold_len();
                    end
                end
            end else if (it.cmd_valid && it.func != FN_UNUSED) begin
                active_cmd = it.func;
                phase      = '0;
                running    = 1'b1;
                if (it.func == FN_WRITE) shift_reg = it.tx_byte;
                if (it.func == FN_READ) begin
                    shift_reg = '0;
                    sda_lvl   = 1'b1;
                end
                enter(it.func, '0, it.sda_in);
                hold_left = hold_len();
            end
            pins.scl_out      = scl_lvl;
            pins.sda_out      = sda_lvl;
            pins.busy_res     = running;
            pins.done_res     = fin;
            pins.rx_byte      = rx_last;
            pins.ack_received = ack_lvl;
            expected_pins.push_back(pins);
        endfunction

        function void check_pins(t_out got);
            t_out want;
            if (expected_pins.size() == 0) begin
                if (pin_errors < 10)
                    $display("unexpected result: scl %0b sda %0b busy %0b done %0b rx %02h ack %0b",
                             got.scl_out, got.sda_out, got.busy_res, got.done_res,
                             got.rx_byte, got.ack_received);
                pin_errors++;
                return;
            end
            want = expected_pins.pop_front();
            if (got.scl_out !== want.scl_out || got.sda_out !== want.sda_out ||
                got.busy_res !== want.busy_res || got.done_res !== want.done_res ||
                got.rx_byte !== want.rx_byte || got.ack_received !== want.ack_received) begin
                if (pin_errors < 10)
                    $display("pin mismatch: exp scl %0b sda %0b busy %0b done %0b rx %02h ack %0b",
                             want.scl_out, want.sda_out, want.busy_res, want.done_res,
                             want.rx_byte, want.ack_received, "\n",
                             "              got scl %0b sda %0b busy %0b done %0b rx %02h ack %0b",
                             got.scl_out, got.sda_out, got.busy_res, got.done_res,
                             got.rx_byte, got.ack_received);
                pin_errors++;
            end
        endfunction
    endclass

    logic       i_clk;
    logic       i_rst_n   = 1'b0;
    logic       in_valid  = 1'b0;
    t_in        in_data   = '0;
    logic       out_ready = 1'b1;
    logic       cfg_valid = 1'b0;
    logic [7:0] cfg_data  = '0;
    logic       in_ready;
    logic       out_valid;
    t_out       out_data;
    logic       cfg_ready;

    int gap_pct   = 0;
    int stall_pct = 0;

    sequencer_pin_checker pin_board;
    logic [2:0]           bus_plan[$];

    wire in_fire  = in_valid & in_ready;
    wire out_fire = out_valid & out_ready;
    wire cfg_fire = cfg_valid & cfg_ready;

    i2c_master_bit_sequencer #(
        .DELAY_WIDTH(DELAY_WIDTH_DEF)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in       (in_data),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out      (out_data),
        .i_cfg_valid(cfg_valid),
        .o_cfg_ready(cfg_ready),
        .i_cfg_data (cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // receiver side: stall at random according to the current phase
    always @(negedge i_clk) begin
        out_ready <= (stall_pct == 0) ? 1'b1 : ($urandom_range(99) >= stall_pct);
    end

    // every accepted result is checked against the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && out_fire) pin_board.check_pins(out_data);
    end

    // hang detector: nothing moving on any channel for too long
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if (in_fire || out_fire || cfg_fire) quiet = 0;
            else quiet++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    // one tick transaction; called and returning at a falling edge
    task automatic send_tick(input t_in it);
        while (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
            in_valid <= 1'b0;
            @(negedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        @(posedge i_clk);
        while (!in_ready) @(posedge i_clk);
        pin_board.note_tick(it);
        @(negedge i_clk);
    endtask

    // issue one command and keep ticking until it completes; commands offered
    // meanwhile must be ignored since the block is busy
    task automatic run_command(input logic [2:0] fn, input logic [7:0] tx, input logic sda);
        t_in it;
        it.cmd_valid = 1'b1;
        it.func      = fn;
        it.tx_byte   = tx;
        it.sda_in    = sda;
        send_tick(it);
        it.func    = FN_START;
        it.tx_byte = ~tx;
        while (pin_board.busy()) send_tick(it);
    endtask

    // stop sending and wait for every predicted result to come back
    task automatic settle();
        in_valid <= 1'b0;
        while (pin_board.pending() != 0) @(negedge i_clk);
    endtask

    task automatic write_half(input logic [7:0] v);
        settle();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge i_clk);
        while (!cfg_ready) @(posedge i_clk);
        pin_board.set_half(v);
        @(negedge i_clk);
        cfg_valid <= 1'b0;
    endtask

    // a well-formed bus transaction: start, address, then writes or reads, stop
    function automatic void plan_transfer();
        int n;
        bus_plan.push_back(FN_START);
        bus_plan.push_back(FN_WRITE);
        bus_plan.push_back(FN_WAITACK);
        n = $urandom_range(1, 3);
        repeat (n) begin
            if ($urandom_range(1)) begin
                bus_plan.push_back(FN_WRITE);
                bus_plan.push_back(FN_WAITACK);
            end else begin
                bus_plan.push_back(FN_READ);
                bus_plan.push_back($urandom_range(1) ? FN_ACK : FN_NACK);
            end
        end
        bus_plan.push_back(FN_STOP);
    endfunction

    function automatic t_in make_tick();
        t_in it;
        it.tx_byte = 8'($urandom_range(255));
        it.sda_in  = 1'($urandom_range(1));
        if (pin_board.busy()) begin
            // noise while busy; the block has to ignore it
            it.cmd_valid = 1'($urandom_range(1));
            it.func      = 3'($urandom_range(7));
        end else begin
            it.cmd_valid = ($urandom_range(99) < 90);
            if (bus_plan.size() == 0) begin
                if ($urandom_range(99) < 85) plan_transfer();
                else bus_plan.push_back(3'($urandom_range(7)));
            end
            if (it.cmd_valid) it.func = bus_plan.pop_front();
            else it.func = 3'($urandom_range(7));
        end
        return it;
    endfunction

    task automatic run_random(input int n, input int gap, input int stall);
        gap_pct   = gap;
        stall_pct = stall;
        repeat (n) send_tick(make_tick());
        gap_pct   = 0;
        stall_pct = 0;
    endtask

    initial begin
        pin_board = new();
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset half-phase length still in force
        run_command(FN_START, 8'h00, 1'b0);

        // directed: every command at the shortest phase, byte extremes,
        // both sda levels for the sampling commands, and the unused code
        write_half(8'd1);
        run_command(FN_START, 8'h5a, 1'b1);
        run_command(FN_WRITE, 8'hff, 1'b0);
        run_command(FN_WRITE, 8'h00, 1'b1);
        run_command(FN_WAITACK, 8'h00, 1'b0);
        run_command(FN_WAITACK, 8'h00, 1'b1);
        run_command(FN_READ, 8'h00, 1'b1);
        run_command(FN_READ, 8'hff, 1'b0);
        run_command(FN_ACK, 8'h00, 1'b1);
        run_command(FN_NACK, 8'h00, 1'b0);
        run_command(FN_UNUSED, 8'hff, 1'b1);
        run_command(FN_WRITE, 8'ha5, 1'b1);
        run_command(FN_STOP, 8'h00, 1'b1);

        // random phases with different phase lengths and back pressure
        run_random(150, 0, 0);
        write_half(8'd0);
        run_random(150, 84, 0);
        write_half(8'd3);
        run_random(150, 0, 84);
        write_half(8'd2);
        run_random(150, 12, 12);

        // longest phase length, one short command only
        write_half(8'd255);
        run_command(FN_ACK, 8'h3c, 1'b0);

        settle();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (pin_board.pin_errors == 0 && pin_board.pending() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/i2cm_pkg.sv
rtl/i2cm_core.sv
rtl/i2c_master_bit_sequencer.sv
rtl/i2cm_checker.sv
tb/tb_i2c_master_bit_sequencer.sv
